/* rtl/core/rshc_pkg.sv */
package rshc_pkg;

  localparam int INDEX_BITS = 10;
  localparam int DEPTH      = 1 << INDEX_BITS;
  localparam int HASH_MULT  = 23;
  localparam int TRIES_W    = INDEX_BITS + 1;
  localparam int WORD_W     = 32;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [TRIES_W-1:0]    tries_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;   // write one zero entry of the clearing pass
    logic load;       // capture the input beat
    logic hash_first; // hash the address, arm the probe limit
    logic rehash;     // step to the next probe slot
    logic rd;         // read the slot at the probe index
    logic commit;     // update the table and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at the last entry
    logic addr_zero;  // captured address is zero
    logic stop;       // slot read is empty or holds the address
    logic tries_zero; // probe limit used up
    logic out_free;   // result register can take a beat
  } sts_t;

endpackage

/* rtl/core/rshc_ctrl.sv */
module rshc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rshc_pkg::sts_t sts_i,
  output rshc_pkg::cmd_t cmd_o
);
  import rshc_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_HASH   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_COMMIT = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        if (sts_i.addr_zero) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.hash_first = 1'b1;
          state_d          = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.stop || sts_i.tries_zero) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.rehash = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

`ifndef SYNTH
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_commit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !in_stall_o)
    else $error("controller not idle after commit");

  a_probe_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.hash_first || cmd_o.rehash) |=> cmd_o.rd)
    else $error("probe index set without a slot read");
`endif
endmodule

/* rtl/core/rshc_datapath.sv */
module rshc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rshc_pkg::cmd_t              cmd_i,
  output rshc_pkg::sts_t              sts_o,
  input  logic                        action_i,
  input  logic [rshc_pkg::WORD_W-1:0] reg_address_i,
  input  logic [rshc_pkg::WORD_W-1:0] new_bits_i,
  input  logic [rshc_pkg::WORD_W-1:0] bit_mask_i,
  input  logic [rshc_pkg::WORD_W-1:0] present_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rshc_pkg::WORD_W-1:0] write_value_o,
  output logic                        table_full_o,
  output logic                        tracked_o,
  output logic                        divergent_o,
  output logic                        first_report_o
);
  import rshc_pkg::*;

  localparam logic [15:0] HASH_MULT_LO = 16'(HASH_MULT);
  localparam tries_t      TRIES_INIT   = tries_t'(DEPTH);
  localparam idx_t        IDX_LAST     = idx_t'(DEPTH - 1);

  typedef struct packed {
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] shadow;
    logic [WORD_W-1:0] cmask;
    logic              reported;
  } entry_t;

  function automatic idx_t hash_of(input logic [WORD_W-1:0] x);
    logic [15:0] xp;
    logic [31:0] prod;
    logic [15:0] mix;
    xp   = x[15:0] + 16'd1;
    prod = 32'(xp) * 32'(HASH_MULT_LO);
    mix  = x[31:16] ^ prod[15:0];
    return mix[INDEX_BITS-1:0];
  endfunction

  // captured beat
  logic              action_q;
  logic [WORD_W-1:0] addr_q, bits_q, mask_q, present_q;

  // probe state
  idx_t   h_q, clr_idx_q;
  tries_t tries_q;
  entry_t rd_q;
  entry_t slot_mem_q [DEPTH];

  // result register
  logic              out_valid_q;
  logic [WORD_W-1:0] wv_q;
  logic              full_q, trk_q, div_q, first_q;

  logic              addr_zero, full, trk, div, first, wr_en;
  logic [WORD_W-1:0] hash_src, merged;
  idx_t              hash_res, wr_idx;
  entry_t            wr_data;

  assign addr_zero = (addr_q == '0);
  assign hash_src  = cmd_i.hash_first ? addr_q : WORD_W'(h_q);
  assign hash_res  = hash_of(hash_src);

  assign full   = !addr_zero && (tries_q == '0);
  assign merged = (present_q & ~mask_q) | (bits_q & mask_q);
  assign trk    = action_q && !addr_zero && !full && (rd_q.addr == addr_q);
  assign div    = trk && (((present_q ^ rd_q.shadow) & rd_q.cmask) != '0);
  assign first  = div && !rd_q.reported;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = h_q;
    wr_data = rd_q;
    if (cmd_i.clr_step) begin
      wr_en   = 1'b1;
      wr_idx  = clr_idx_q;
      wr_data = '0;
    end else if (cmd_i.commit && !addr_zero && !full) begin
      if (!action_q) begin
        wr_en          = 1'b1;
        wr_data.addr   = addr_q;
        wr_data.shadow = (rd_q.shadow & ~mask_q) | (bits_q & mask_q);
        wr_data.cmask  = rd_q.cmask | mask_q;
      end else if (first) begin
        wr_en            = 1'b1;
        wr_data.reported = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem_q[wr_idx] <= wr_data;
    if (cmd_i.rd) rd_q <= slot_mem_q[h_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q  <= action_i;
      addr_q    <= reg_address_i;
      bits_q    <= new_bits_i;
      mask_q    <= bit_mask_i;
      present_q <= present_value_i;
    end
    if (cmd_i.commit) begin
      wv_q    <= action_q ? '0 : merged;
      full_q  <= full;
      trk_q   <= trk;
      div_q   <= div;
      first_q <= first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q   <= '0;
      h_q         <= '0;
      tries_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_idx_q <= clr_idx_q + idx_t'(1);
      if (cmd_i.load) tries_q <= TRIES_INIT;
      if (cmd_i.hash_first) begin
        h_q     <= hash_res;
        tries_q <= TRIES_INIT;
      end else if (cmd_i.rehash) begin
        h_q     <= hash_res;
        tries_q <= tries_q - tries_t'(1);
      end
      if (cmd_i.commit)      out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.clr_last   = (clr_idx_q == IDX_LAST);
  assign sts_o.addr_zero  = addr_zero;
  assign sts_o.stop       = (rd_q.addr == '0) || (rd_q.addr == addr_q);
  assign sts_o.tries_zero = (tries_q == '0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign write_value_o  = wv_q;
  assign table_full_o   = full_q;
  assign tracked_o      = trk_q;
  assign divergent_o    = div_q;
  assign first_report_o = first_q;

`ifndef SYNTH
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  a_flag_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((!first_q || div_q) && (!div_q || trk_q) && (!trk_q || !full_q)))
    else $error("inconsistent verify flags");

  a_verify_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && trk_q) |-> (wv_q == '0))
    else $error("verify result carries a write value");
`endif
endmodule

/* rtl/core/register_shadow_hash_checker_core.sv */
// register shadow hash checker
// input channel: in_valid_i / in_stall_o carry one beat per item: action_i
//   (0 record masked write, 1 verify), reg_address_i, new_bits_i,
//   bit_mask_i, present_value_i
// output channel: out_valid_o / out_stall_i carry one result beat per item:
//   write_value_o, table_full_o, tracked_o, divergent_o, first_report_o
// one item is in flight at a time; each probe step is one read of the
//   single-port slot table plus a compare
// address zero skips the hash and the probe loop and goes straight to the
//   commit step
// after reset a clearing pass zeroes all DEPTH (1024) table entries, with
//   in_stall_o high throughout
// a stalled result holds in the output register; the next item is taken
//   meanwhile and waits at its commit step until the register frees
module register_shadow_hash_checker_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [rshc_pkg::WORD_W-1:0] reg_address_i,
  input  logic [rshc_pkg::WORD_W-1:0] new_bits_i,
  input  logic [rshc_pkg::WORD_W-1:0] bit_mask_i,
  input  logic [rshc_pkg::WORD_W-1:0] present_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rshc_pkg::WORD_W-1:0] write_value_o,
  output logic                        table_full_o,
  output logic                        tracked_o,
  output logic                        divergent_o,
  output logic                        first_report_o
);
  import rshc_pkg::*;

  // command and status between sequencer and table datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, capture, hash, probe loop, commit
  rshc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot table, hash unit, merge and divergence check, result register
  rshc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .reg_address_i   (reg_address_i),
    .new_bits_i      (new_bits_i),
    .bit_mask_i      (bit_mask_i),
    .present_value_i (present_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_value_o   (write_value_o),
    .table_full_o    (table_full_o),
    .tracked_o       (tracked_o),
    .divergent_o     (divergent_o),
    .first_report_o  (first_report_o)
  );

endmodule

/* tb/sv/tb_register_shadow_hash_checker_core.sv */
module tb_register_shadow_hash_checker_core;
  import rshc_pkg::*;

  // item kinds on action_i
  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_VERIFY = 1'b1
  } action_e;

  // one result beat, field for field
  typedef struct packed {
    logic [WORD_W-1:0] write_value;
    logic              table_full;
    logic              tracked;
    logic              divergent;
    logic              first_report;
  } verdict_t;

  localparam int RandomItems = 1300;
  localparam int LongHold    = 300;
  // sized for a full-length probe, which makes up to DEPTH + 1 slot reads
  localparam int DrainCycles = 2 * DEPTH + 8;
  // longest silent stretch of a correct run: a full-length probe behind a long
  // hold and a run of random stalls, taken several times over; the clearing
  // pass after reset fits well inside
  localparam int QuietLimit  = 5 * (2 * DEPTH + 4 + LongHold + 200);

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              action_i        = 1'b0;
  logic [WORD_W-1:0] reg_address_i   = '0;
  logic [WORD_W-1:0] new_bits_i      = '0;
  logic [WORD_W-1:0] bit_mask_i      = '0;
  logic [WORD_W-1:0] present_value_i = '0;
  logic              out_stall_i     = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [WORD_W-1:0] write_value_o;
  logic              table_full_o;
  logic              tracked_o;
  logic              divergent_o;
  logic              first_report_o;

  register_shadow_hash_checker_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .reg_address_i  (reg_address_i),
    .new_bits_i     (new_bits_i),
    .bit_mask_i     (bit_mask_i),
    .present_value_i(present_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_value_o  (write_value_o),
    .table_full_o   (table_full_o),
    .tracked_o      (tracked_o),
    .divergent_o    (divergent_o),
    .first_report_o (first_report_o)
  );

  // shadow table as the testbench sees it, zero address means empty
  logic [WORD_W-1:0] shadow_addr [DEPTH];
  logic [WORD_W-1:0] shadow_bits [DEPTH];
  logic [WORD_W-1:0] shadow_mask [DEPTH];
  logic              shadow_flag [DEPTH];

  verdict_t          expected_verdicts [$];
  logic [WORD_W-1:0] addr_pool [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  bit failed         = 1'b0;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // start slot of an address, and also the step from one slot to the next
  function automatic idx_t slot_hash(logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] lo;
    lo = ((x + 32'd1) & 32'h0000_FFFF) * HASH_MULT;
    return idx_t'((x >> 16) ^ (lo & 32'h0000_FFFF));
  endfunction

  // walk from the start slot past slots owned by other addresses; gives up
  // after DEPTH steps even if the last slot reached would do
  function automatic bit find_slot(logic [WORD_W-1:0] addr, output idx_t slot);
    idx_t h;
    int   tries;
    h     = slot_hash(addr);
    tries = DEPTH;
    while (shadow_addr[h] != '0 && shadow_addr[h] != addr && tries > 0) begin
      h = slot_hash(WORD_W'(h));
      tries--;
    end
    slot = h;
    return tries != 0;
  endfunction

  // expected result of one item; updates the shadow table as the block would
  function automatic verdict_t predict_register_check(action_e act,
      logic [WORD_W-1:0] addr, bits, mask, present);
    verdict_t v;
    idx_t     s;
    v = '0;
    if (act == ACT_RECORD) begin
      v.write_value = (present & ~mask) | (bits & mask);
      if (addr != '0) begin
        if (find_slot(addr, s)) begin
          shadow_addr[s] = addr;
          shadow_bits[s] = (shadow_bits[s] & ~mask) | (bits & mask);
          shadow_mask[s] = shadow_mask[s] | mask;
        end else begin
          v.table_full = 1'b1;
        end
      end
    end else if (addr != '0) begin
      if (!find_slot(addr, s)) begin
        v.table_full = 1'b1;
      end else if (shadow_addr[s] == addr) begin
        v.tracked = 1'b1;
        if (((present ^ shadow_bits[s]) & shadow_mask[s]) != '0) begin
          v.divergent = 1'b1;
          if (!shadow_flag[s]) begin
            v.first_report = 1'b1;
            shadow_flag[s] = 1'b1;
          end
        end
      end
    end
    return v;
  endfunction

  // address whose hash lands on the given slot, random otherwise
  function automatic logic [WORD_W-1:0] address_at(idx_t slot);
    logic [15:0] lo;
    logic [5:0]  top;
    lo  = 16'($urandom_range(16'hFFFF, 1));
    top = 6'($urandom);
    return {top, slot ^ slot_hash({16'h0, lo}), lo};
  endfunction

  // readback for a verify: the shadow, half the time with flipped bits
  function automatic logic [WORD_W-1:0] observed_value(logic [WORD_W-1:0] addr);
    idx_t              s;
    logic [WORD_W-1:0] v;
    v = $urandom;
    if (find_slot(addr, s) && shadow_addr[s] == addr) begin
      v = shadow_bits[s];
      case ($urandom_range(3))
        0: v = v ^ (32'd1 << $urandom_range(31));
        1: v = v ^ $urandom;
        default: ;
      endcase
    end
    return v;
  endfunction

  // one input beat; valid is lowered only while idling so that back-to-back
  // beats keep it high without a second assignment in the same step
  task automatic send_beat(action_e act, logic [WORD_W-1:0] addr, bits, mask, present);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    reg_address_i   <= addr;
    new_bits_i      <= bits;
    bit_mask_i      <= mask;
    present_value_i <= present;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // beat taken at this edge
    expected_verdicts.push_back(predict_register_check(act, addr, bits, mask, present));
  endtask

  // sender goes quiet, then waits for every outstanding result
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // mostly record and verify on a pool of colliding addresses, with fresh
  // addresses and address zero as noise
  task automatic run_random_items(int count);
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] mask;
    int                pick;
    repeat (count) begin
      pick = $urandom_range(99);
      addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
      case ($urandom_range(3))
        0: mask = '1;
        1: mask = '0;
        default: mask = $urandom;
      endcase
      if (pick < 40) begin
        send_beat(ACT_RECORD, addr, $urandom, mask, $urandom);
      end else if (pick < 75) begin
        send_beat(ACT_VERIFY, addr, $urandom, $urandom, observed_value(addr));
      end else if (pick < 85) begin
        send_beat(ACT_RECORD, $urandom, $urandom, mask, $urandom);
      end else if (pick < 95) begin
        send_beat(ACT_VERIFY, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_beat(action_e'($urandom_range(1)), '0, $urandom, mask, $urandom);
      end
    end
  endtask

  task automatic test_directed_cases();
    logic [WORD_W-1:0] twin_a;
    logic [WORD_W-1:0] twin_b;
    idx_t              twin_slot;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // all-ones address: full write, matching readback, divergence, repeat
    send_beat(ACT_RECORD, '1, '1, '1, '0);
    send_beat(ACT_VERIFY, '1, '0, '0, '1);
    send_beat(ACT_VERIFY, '1, '0, '0, '0);
    send_beat(ACT_VERIFY, '1, '1, '1, 32'h0000_0001);
    // empty mask returns the present value and leaves the shadow alone
    send_beat(ACT_RECORD, '1, 32'hDEAD_BEEF, '0, 32'h1234_5678);
    // lowest address, upper half only
    send_beat(ACT_RECORD, 32'd1, '0, 32'hFFFF_0000, '1);
    send_beat(ACT_VERIFY, 32'd1, '1, '1, 32'h0000_FFFF);
    send_beat(ACT_VERIFY, 32'd1, '1, '1, 32'hFFFF_0000);
    // alternating bit patterns
    send_beat(ACT_RECORD, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    send_beat(ACT_VERIFY, 32'hAAAA_AAAA, '0, '0, 32'h5555_5555);
    // address never written
    send_beat(ACT_VERIFY, 32'h8000_0000, '0, '0, 32'h8000_0000);
    // address zero on both kinds
    send_beat(ACT_RECORD, '0, '1, 32'h0F0F_0F0F, '0);
    send_beat(ACT_VERIFY, '0, '0, '0, '1);
    // two addresses on one start slot, the second one probes on
    twin_slot = idx_t'($urandom);
    twin_a    = address_at(twin_slot);
    twin_b    = address_at(twin_slot);
    send_beat(ACT_RECORD, twin_a, 32'h0000_1111, 32'h0000_FFFF, '1);
    send_beat(ACT_RECORD, twin_b, '1, '1, '0);
    send_beat(ACT_VERIFY, twin_b, '0, '0, 32'hFFFF_FFFE);
    send_beat(ACT_VERIFY, twin_a, '0, '0, 32'hFFFF_1111);
    // a second write widens the check mask, same readback now diverges
    send_beat(ACT_RECORD, twin_a, 32'h2222_0000, 32'hFFFF_0000, '0);
    send_beat(ACT_VERIFY, twin_a, '0, '0, 32'hFFFF_1111);
  endtask

  task automatic test_random_traffic();
    idx_t home;
    // groups of addresses sharing a start slot
    repeat (12) begin
      home = idx_t'($urandom);
      repeat (4) addr_pool.push_back(address_at(home));
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_items(RandomItems / 4);
    send_idle_pct  = 74;
    recv_stall_pct = 0;
    run_random_items(RandomItems / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 74;
    run_random_items(RandomItems / 4);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    run_random_items(RandomItems / 4);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // long receiver hold while the sender keeps offering beats
    hold_request = LongHold;
    run_random_items(16);
    // sender pauses until the block has handed back everything
    wait_for_results();
    run_random_items(8);
  endtask

  task automatic test_probe_exhaustion();
    idx_t              ring [$];
    idx_t              s;
    idx_t              start;
    logic [WORD_W-1:0] probe_addr;
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    // the rehash steps form a cycle through the start slot
    start = idx_t'($urandom);
    s     = start;
    do begin
      ring.push_back(s);
      s = slot_hash(WORD_W'(s));
    end while (s != start);
    // occupy every empty slot of the cycle
    foreach (ring[k]) begin
      if (shadow_addr[ring[k]] == '0) begin
        send_beat(ACT_RECORD, address_at(ring[k]), $urandom, $urandom, $urandom);
      end
    end
    // a new address on the cycle now finds no slot
    probe_addr = address_at(start);
    send_beat(ACT_VERIFY, probe_addr, $urandom, $urandom, $urandom);
    send_beat(ACT_RECORD, probe_addr, $urandom, $urandom, $urandom);
    // an address already on the cycle is still found
    probe_addr = shadow_addr[ring[0]];
    send_beat(ACT_VERIFY, probe_addr, $urandom, $urandom, observed_value(probe_addr));
  endtask

  // result checking and receiver stall, one process
  always @(posedge clk_i) begin : result_monitor
    verdict_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("result beat with no item outstanding");
        failed = 1'b1;
      end else begin
        want = expected_verdicts.pop_front();
        if (write_value_o !== want.write_value) begin
          $error("write_value: expected %h, got %h", want.write_value, write_value_o);
          failed = 1'b1;
        end
        if (table_full_o !== want.table_full) begin
          $error("table_full: expected %0b, got %0b", want.table_full, table_full_o);
          failed = 1'b1;
        end
        if (tracked_o !== want.tracked) begin
          $error("tracked: expected %0b, got %0b", want.tracked, tracked_o);
          failed = 1'b1;
        end
        if (divergent_o !== want.divergent) begin
          $error("divergent: expected %0b, got %0b", want.divergent, divergent_o);
          failed = 1'b1;
        end
        if (first_report_o !== want.first_report) begin
          $error("first_report: expected %0b, got %0b", want.first_report, first_report_o);
          failed = 1'b1;
        end
      end
    end
    // a requested long hold is counted here, otherwise random stalls
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ends the run once nothing has moved on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("register_shadow_hash_checker_core verification failed");
    $finish;
  end

  initial begin : test_sequence
    foreach (shadow_addr[k]) begin
      shadow_addr[k] = '0;
      shadow_bits[k] = '0;
      shadow_mask[k] = '0;
      shadow_flag[k] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block clears its table first and stalls input meanwhile
    test_directed_cases();
    test_random_traffic();
    test_backpressure();
    test_probe_exhaustion();
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed) begin
      $display("register_shadow_hash_checker_core verification clean");
    end else begin
      $display("register_shadow_hash_checker_core verification failed");
    end
    $finish;
  end

endmodule

/* register_shadow_hash_checker_core.f */
rtl/core/rshc_pkg.sv
rtl/core/rshc_ctrl.sv
rtl/core/rshc_datapath.sv
rtl/core/register_shadow_hash_checker_core.sv
tb/sv/tb_register_shadow_hash_checker_core.sv
